### rtl/trace_record_deframe_filter_top_defines.svh
// assertion macros for the trace record deframe filter
`ifndef TRACE_RECORD_DEFRAME_FILTER_TOP_DEFINES_SVH
`define TRACE_RECORD_DEFRAME_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define TRDF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define TRDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/trdf_pkg.sv
// package: constants and types of the trace record deframe filter
package trdf_pkg;

    localparam int TERMS   = 32;
    localparam int TERM_AW = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int CNT_W   = TERM_AW + 1;

    localparam int CFG_W   = 8;
    localparam logic CFG_TERM_COUNT = 1'b0;
    localparam logic CFG_START_BYTE = 1'b1;

    localparam logic       CMD_TERM   = 1'b0;
    localparam logic       CMD_WORD   = 1'b1;
    localparam logic [4:0] CLASS_ANY  = 5'd16;
    localparam logic [4:0] CLASS_LOG  = 5'd17;
    localparam logic [3:0] TYPE_LOG   = 4'd12;
    localparam logic [3:0] TYPE_OBJ_LO = 4'd1;
    localparam logic [3:0] TYPE_OBJ_HI = 4'd5;
    localparam int         N_KEEP     = 5;

    typedef struct packed {
        logic        exclude;
        logic [4:0]  cls;
        logic        has_id;
        logic [11:0] id;
        logic [6:0]  level;
    } t_term;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_STAMP   = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        CT_RUN  = 3'b001,
        CT_WALK = 3'b010,
        CT_PUSH = 3'b100
    } t_ctl;

endpackage

### rtl/trace_record_deframe_filter_top.sv
// top level: trace record deframer with a serial include/exclude term filter
//
// input channel (i_in_valid / o_in_ready): one beat is either a filter term
// write (i_command = 0, slot and term fields) or one 32-bit trace word
// (i_command = 1). every beat that does not complete a record is taken.
// the beat that completes a record (stamp word of an empty record, or its
// last payload word) starts the filter: the term memory is read one slot
// a cycle over the first n slots, n being term_count clamped to the table
// depth, and the block takes no beat until the walk and the push are done
// (no walk for record types that the table does not judge, or when n is zero).
// output channel (o_out_valid / i_out_ready): one beat per shown record,
// from an output register loaded on the edge that reopens the input; the
// next record is deframed while it waits.
// if a further record is judged and shown while the receiver still stalls,
// the block holds off the input until the register frees up.
// configuration: i_cfg_we with i_cfg_idx 0 (term_count) or 1 (start_byte), taken at
// once; the user must write only while no record is being judged (not enforced by the block).
// reset (synchronous, active low) returns to header hunt with all holds
// cleared; the term memory keeps whatever it held and must be written
// before use.
`include "trace_record_deframe_filter_top_defines.svh"

module trace_record_deframe_filter_top
    import trdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration port
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_command,
    input  logic [31:0]      i_trace_word,
    input  logic [4:0]       i_term_slot,
    input  logic             i_term_exclude,
    input  logic [4:0]       i_term_class,
    input  logic             i_term_has_id,
    input  logic [11:0]      i_term_id,
    input  logic [6:0]       i_term_level,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [3:0]       o_rec_type,
    output logic [15:0]      o_meta,
    output logic [31:0]      o_stamp,
    output logic [3:0]       o_word_count,
    output logic [31:0]      o_word_first,
    output logic [31:0]      o_arg_one,
    output logic [31:0]      o_arg_two,
    output logic [31:0]      o_arg_three,
    output logic [31:0]      o_arg_four,
    output logic             o_resynced
);

    // configuration registers
    logic [5:0]  r_term_count;
    logic [7:0]  r_start_byte;

    // deframer state
    t_phase      r_phase;
    logic [3:0]  r_words_left;
    logic [31:0] r_header;
    logic [31:0] r_stamp;
    logic [31:0] r_payload [N_KEEP];
    logic        r_resync;

    // control and filter walk
    t_ctl              r_ctl;
    t_ctl              n_ctl;
    logic [CNT_W-1:0]  r_walk_idx;
    logic              r_rd_vld;
    t_term             r_rd_data;
    logic              r_any_inc;
    logic              r_hit_inc;
    logic              r_hit_exc;

    // term memory, one read port and one write port
    t_term       r_term_mem [TERMS];

    // output register
    logic        r_out_valid;
    logic [3:0]  r_out_type;
    logic [15:0] r_out_meta;
    logic [31:0] r_out_stamp;
    logic [3:0]  r_out_count;
    logic [31:0] r_out_word [N_KEEP];
    logic        r_out_resync;

    logic             in_fire;
    logic             word_fire;
    logic             mem_we;
    logic             rd_en;
    logic             finish;
    logic             judged;
    logic             shown;
    logic             out_free;
    logic [CNT_W-1:0] walk_n;
    logic [3:0]       hdr_len;
    logic [3:0]       hdr_type;
    logic [15:0]      hdr_meta;
    logic [3:0]       pay_idx;
    t_term            wr_term;

    // does one term hit the record held in the header register
    function automatic logic term_hits(input t_term t, input logic [3:0] typ,
                                       input logic [15:0] meta);
        logic hit;
        if (t.cls == CLASS_ANY) begin
            hit = 1'b1;
        end else if (typ == TYPE_LOG) begin
            hit = (t.cls == CLASS_LOG) && (meta <= {9'd0, t.level});
        end else if (t.cls != {1'b0, meta[15:12]}) begin
            hit = 1'b0;
        end else if (t.has_id) begin
            hit = (t.id == meta[11:0]);
        end else begin
            hit = 1'b1;
        end
        return hit;
    endfunction

    assign hdr_len  = r_header[11:8];
    assign hdr_type = r_header[15:12];
    assign hdr_meta = r_header[31:16];
    assign pay_idx  = hdr_len - r_words_left;

    // only object and log records consult the table
    assign judged = ((hdr_type >= TYPE_OBJ_LO) && (hdr_type <= TYPE_OBJ_HI))
                    || (hdr_type == TYPE_LOG);

    // counts above the table depth are clamped
    assign walk_n = (32'(r_term_count) > TERMS) ? CNT_W'(TERMS) : CNT_W'(r_term_count);

    assign o_in_ready = (r_ctl == CT_RUN);
    assign in_fire    = i_in_valid && o_in_ready;
    assign word_fire  = in_fire && (i_command == CMD_WORD);
    assign mem_we     = in_fire && (i_command == CMD_TERM) && (32'(i_term_slot) < TERMS);
    assign rd_en      = (r_ctl == CT_WALK) && (r_walk_idx < walk_n);

    // record completes on the stamp of an empty record or the last payload word
    assign finish = word_fire && (((r_phase == PH_STAMP) && (hdr_len == 4'd0))
                                  || ((r_phase == PH_PAYLOAD) && (r_words_left == 4'd1)));

    assign shown    = !r_hit_exc && (!r_any_inc || r_hit_inc);
    assign out_free = !r_out_valid || i_out_ready;

    assign wr_term = '{exclude: i_term_exclude, cls: i_term_class, has_id: i_term_has_id,
                       id: i_term_id, level: i_term_level};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= '0;
            r_start_byte <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TERM_COUNT: r_term_count <= i_cfg_data[5:0];
                CFG_START_BYTE: r_start_byte <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // term memory: writes only while running, reads only while walking
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_term_mem[TERM_AW'(i_term_slot)] <= wr_term;
        end
        if (rd_en) begin
            r_rd_data <= r_term_mem[r_walk_idx[TERM_AW-1:0]];
        end
    end

    // deframer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_words_left <= '0;
            r_header     <= '0;
            r_stamp      <= '0;
            r_resync     <= 1'b0;
            for (int k = 0; k < N_KEEP; k++) begin
                r_payload[k] <= '0;
            end
        end else begin
            if (word_fire) begin
                unique case (r_phase)
                    PH_STAMP: begin
                        r_stamp <= i_trace_word;
                        if (hdr_len == 4'd0) begin
                            r_phase      <= PH_HEADER;
                            r_words_left <= '0;
                        end else begin
                            r_phase      <= PH_PAYLOAD;
                            r_words_left <= hdr_len;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (pay_idx < 4'(N_KEEP)) begin
                            r_payload[pay_idx[2:0]] <= i_trace_word;
                        end
                        r_words_left <= r_words_left - 4'd1;
                        if (r_words_left == 4'd1) begin
                            r_phase <= PH_HEADER;
                        end
                    end
                    default: begin
                        // header hunt
                        if (i_trace_word[7:0] != r_start_byte) begin
                            r_resync <= 1'b1;
                            r_phase  <= PH_HEADER;
                        end else begin
                            r_header     <= i_trace_word;
                            r_phase      <= PH_STAMP;
                            r_words_left <= '0;
                            for (int k = 0; k < N_KEEP; k++) begin
                                r_payload[k] <= '0;
                            end
                        end
                    end
                endcase
            end
            // resync mark belongs to the record just judged
            if ((r_ctl == CT_PUSH) && (out_free || !shown)) begin
                r_resync <= 1'b0;
            end
        end
    end

    // control sequence
    always_comb begin
        n_ctl = r_ctl;
        unique case (r_ctl)
            CT_RUN: begin
                if (finish) begin
                    n_ctl = (judged && (walk_n != '0)) ? CT_WALK : CT_PUSH;
                end
            end
            CT_WALK: begin
                if ((r_walk_idx == walk_n) && !r_rd_vld) begin
                    n_ctl = CT_PUSH;
                end
            end
            CT_PUSH: begin
                if (out_free || !shown) begin
                    n_ctl = CT_RUN;
                end
            end
            default: n_ctl = CT_RUN;
        endcase
    end

    // filter walk: one slot read a cycle, each verdict gathered in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= CT_RUN;
            r_walk_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_any_inc  <= 1'b0;
            r_hit_inc  <= 1'b0;
            r_hit_exc  <= 1'b0;
        end else begin
            r_ctl    <= n_ctl;
            r_rd_vld <= rd_en;
            if (finish) begin
                r_walk_idx <= '0;
                r_any_inc  <= 1'b0;
                r_hit_inc  <= 1'b0;
                r_hit_exc  <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_walk_idx <= r_walk_idx + CNT_W'(1);
                end
                if (r_rd_vld) begin
                    if (!r_rd_data.exclude) begin
                        r_any_inc <= 1'b1;
                    end
                    if (term_hits(r_rd_data, hdr_type, hdr_meta)) begin
                        if (r_rd_data.exclude) begin
                            r_hit_exc <= 1'b1;
                        end else begin
                            r_hit_inc <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_ctl == CT_PUSH) && out_free && shown) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_ctl == CT_PUSH) && out_free && shown) begin
            r_out_type   <= hdr_type;
            r_out_meta   <= hdr_meta;
            r_out_stamp  <= r_stamp;
            r_out_count  <= hdr_len;
            r_out_resync <= r_resync;
            for (int k = 0; k < N_KEEP; k++) begin
                r_out_word[k] <= r_payload[k];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rec_type   = r_out_type;
    assign o_meta       = r_out_meta;
    assign o_stamp      = r_out_stamp;
    assign o_word_count = r_out_count;
    assign o_word_first = r_out_word[0];
    assign o_arg_one    = r_out_word[1];
    assign o_arg_two    = r_out_word[2];
    assign o_arg_three  = r_out_word[3];
    assign o_arg_four   = r_out_word[4];
    assign o_resynced   = r_out_resync;

    // checks
    `TRDF_ASSERT_IMP(a_no_rw_clash, rd_en, !mem_we, "term memory read and write overlap")
    `TRDF_ASSERT_IMP(a_rd_in_walk, r_rd_vld, $past(r_ctl == CT_WALK), "read data outside walk")
    `TRDF_ASSERT_NXT(a_push_loads, (r_ctl == CT_PUSH) && out_free && shown, o_out_valid,
                     "shown record not loaded")
    `TRDF_ASSERT_IMP(a_no_accept_busy, (r_ctl != CT_RUN), !in_fire, "beat taken while judging")

endmodule
